[design/teq_pkg.sv]
// teq_pkg: shared types, constants and codes for the timed event queue
// used by teq_cell, teq_chain and timed_event_queue; no dependencies

package teq_pkg;

  // queue sizing
  localparam int unsigned QUEUE_DEPTH     = 64;
  localparam int unsigned MAX_PER_SERVICE = 10;
  localparam int unsigned TIME_W          = 48;

  // field widths
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned SRC_W    = 16;
  localparam int unsigned DLY_W    = 32;
  localparam int unsigned SCALE_W  = 16;
  localparam int unsigned SCALE_FRAC = 8;
  localparam int unsigned PROD_W   = DLY_W + SCALE_W;
  localparam int unsigned TTN_W    = TIME_W + 1;
  localparam int unsigned QCOUNT_W = 7;

  // derived counter widths
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SCNT_W = $clog2(MAX_PER_SERVICE + 1);
  localparam int unsigned BUF_IW = (MAX_PER_SERVICE > 1) ? $clog2(MAX_PER_SERVICE) : 1;

  // stream widths
  localparam int unsigned IN_DATA_W  = 168;
  localparam int unsigned OUT_DATA_W = 144;

  // 600 s in 1/1024 s units
  localparam logic [TTN_W-1:0] EMPTY_WAIT = TTN_W'(614400);
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(256);

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_SERVICE = 2'd1,
    CMD_CLEAN   = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CH_HOLD = 2'd0,
    CH_INS  = 2'd1,
    CH_POP  = 2'd2
  } chain_op_e;

  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] due;
    logic [TAG_W-1:0]  tag;
    logic [SRC_W-1:0]  src;
  } entry_t;

  typedef struct packed {
    chain_op_e op;
    entry_t    item;
  } chain_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_INS,
    ST_POP,
    ST_STAT,
    ST_EMIT
  } state_e;

endpackage

[design/timed_event_queue.sv]
// timed_event_queue: time-ordered event queue with add, service, clean and nop commands
// steps: add runs multiply, sum, insert, status, emit; clean/nop run status, emit; service pops, then status, emit
// throughput: one item at a time; a service releases one entry per cycle from the cell chain
// head, then emits n beats (or one status beat), one per cycle while m_axis_tready_i is high
// reset (async, active low): queue empty, dirty clear, delay_scale 256; no clearing pass
// depends on teq_pkg and teq_chain

module timed_event_queue (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration: delay_scale
  input  logic                               cfg_we_i,
  input  logic [teq_pkg::SCALE_W-1:0]        cfg_wdata_i,
  // input beats
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // now_time, has_abs_time, abs_time, has_delay, delay, op_tag, source_id, zero pad
  input  logic [teq_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // cmd
  input  logic [1:0]                         s_axis_tuser_i,
  // result beats
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // out_tag, out_source, dispatch_time, more_ready, queue_count, dirty,
  // time_to_next, overflow, zero pad
  output logic [teq_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  // dispatch_valid
  output logic                               m_axis_tuser_o,
  output logic                               m_axis_tlast_o
);
  import teq_pkg::*;

  state_e state_q, state_d;

  cmd_e              cmd_q;
  logic [TIME_W-1:0] now_q;
  logic              has_abs_q;
  logic [TIME_W-1:0] abs_q;
  logic              has_dly_q;
  logic [DLY_W-1:0]  dly_q;
  logic [TAG_W-1:0]  tag_q;
  logic [SRC_W-1:0]  src_q;
  logic [PROD_W-1:0] prod_q;
  logic [TIME_W-1:0] due_q;
  logic [SCALE_W-1:0] scale_q;
  logic [QCNT_W-1:0] count_q;
  logic              dirty_q;
  logic              ovf_q;
  logic [SCNT_W-1:0] n_q;
  logic [BUF_IW-1:0] idx_q;
  logic              more_q;
  logic [TTN_W-1:0]  ttn_q;
  logic [TAG_W-1:0]  buf_tag_q [MAX_PER_SERVICE];
  logic [SRC_W-1:0]  buf_src_q [MAX_PER_SERVICE];

  chain_cmd_t chain_cmd;
  entry_t     head;
  logic       in_beat, out_beat;
  logic       full, head_due, do_pop, last_beat;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] due_d;

  assign in_beat  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_beat = m_axis_tvalid_o && m_axis_tready_i;

  assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign head_due = head.valid && (head.due <= now_q);
  assign do_pop   = (state_q == ST_POP) && head_due
                    && (n_q < SCNT_W'(MAX_PER_SERVICE));
  assign last_beat = (n_q == '0) || ((SCNT_W'(idx_q) + SCNT_W'(1)) == n_q);

  // due time: absolute time if given, else now plus scaled delay (saturating), else now
  assign sum = {1'b0, now_q} + (TIME_W+1)'(prod_q[PROD_W-1:SCALE_FRAC]);
  always_comb begin
    if (has_abs_q) begin
      due_d = abs_q;
    end else if (has_dly_q) begin
      due_d = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    end else begin
      due_d = now_q;
    end
  end

  // chain command
  always_comb begin
    chain_cmd.op   = CH_HOLD;
    chain_cmd.item = '{valid: 1'b1, due: due_q, tag: tag_q, src: src_q};
    if (state_q == ST_INS && !full) begin
      chain_cmd.op = CH_INS;
    end else if (do_pop) begin
      chain_cmd.op = CH_POP;
    end
  end

  teq_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (chain_cmd),
    .head_o (head)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          unique case (cmd_e'(s_axis_tuser_i))
            CMD_ADD:     state_d = ST_MUL;
            CMD_SERVICE: state_d = ST_POP;
            default:     state_d = ST_STAT;
          endcase
        end
      end
      ST_MUL:  state_d = ST_SUM;
      ST_SUM:  state_d = ST_INS;
      ST_INS:  state_d = ST_STAT;
      ST_POP: begin
        if (!do_pop) state_d = ST_STAT;
      end
      ST_STAT: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_beat && last_beat) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
      count_q <= '0;
      dirty_q <= 1'b0;
      ovf_q   <= 1'b0;
      n_q     <= '0;
      idx_q   <= '0;
      more_q  <= 1'b0;
    end else begin
      if (cfg_we_i) scale_q <= cfg_wdata_i;
      if (in_beat) begin
        ovf_q  <= 1'b0;
        n_q    <= '0;
        idx_q  <= '0;
        more_q <= 1'b0;
        if (cmd_e'(s_axis_tuser_i) == CMD_CLEAN) dirty_q <= 1'b0;
      end
      if (state_q == ST_INS) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + QCNT_W'(1);
          dirty_q <= 1'b1;
        end
      end
      if (do_pop) begin
        count_q <= count_q - QCNT_W'(1);
        n_q     <= n_q + SCNT_W'(1);
      end else if (state_q == ST_POP) begin
        more_q <= head_due;
      end
      if (state_q == ST_EMIT && out_beat && !last_beat) begin
        idx_q <= idx_q + BUF_IW'(1);
      end
    end
  end

  // item payload and arithmetic
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      cmd_q     <= cmd_e'(s_axis_tuser_i);
      now_q     <= s_axis_tdata_i[47:0];
      has_abs_q <= s_axis_tdata_i[48];
      abs_q     <= s_axis_tdata_i[96:49];
      has_dly_q <= s_axis_tdata_i[97];
      dly_q     <= s_axis_tdata_i[129:98];
      tag_q     <= s_axis_tdata_i[145:130];
      src_q     <= s_axis_tdata_i[161:146];
    end
    if (state_q == ST_MUL) prod_q <= PROD_W'(dly_q) * PROD_W'(scale_q);
    if (state_q == ST_SUM) due_q <= due_d;
    if (state_q == ST_STAT) begin
      ttn_q <= (count_q == '0) ? EMPTY_WAIT
                               : ({1'b0, head.due} - {1'b0, now_q});
    end
    if (do_pop) begin
      buf_tag_q[n_q[BUF_IW-1:0]] <= head.tag;
      buf_src_q[n_q[BUF_IW-1:0]] <= head.src;
    end
  end

  // result beat
  logic              rel;
  logic [TAG_W-1:0]  out_tag;
  logic [SRC_W-1:0]  out_src;
  logic [TIME_W-1:0] out_time;

  assign rel      = (n_q != '0);
  assign out_tag  = rel ? buf_tag_q[idx_q] : '0;
  assign out_src  = rel ? buf_src_q[idx_q] : '0;
  assign out_time = rel ? now_q : '0;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_EMIT);
  assign m_axis_tuser_o  = rel;
  assign m_axis_tlast_o  = last_beat;
  assign m_axis_tdata_o  = {5'd0,
                            ovf_q && (cmd_q == CMD_ADD),
                            ttn_q,
                            dirty_q,
                            QCOUNT_W'(count_q),
                            last_beat && more_q,
                            out_time,
                            out_src,
                            out_tag};

`ifndef SYNTH
  // queue occupancy never exceeds the chain length
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  // chain head holds an entry exactly when the count is nonzero
  a_head_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head.valid == (count_q != '0))
    else $error("chain head disagrees with count");

  // release count bounded per service pass
  a_release_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= SCNT_W'(MAX_PER_SERVICE))
    else $error("too many releases in one pass");

  // dropped add on a full queue raises overflow
  a_drop_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INS && full) |=> ovf_q)
    else $error("full queue add did not flag overflow");

  // overflow never appears alongside a release
  a_ovf_no_rel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (n_q == '0))
    else $error("overflow with released entries");
`endif

endmodule

[design/teq_cell.sv]
// teq_cell: one slot of the sorted entry chain
// depends on teq_pkg for entry and command types

module teq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  teq_pkg::chain_cmd_t cmd_i,
  input  teq_pkg::entry_t     left_i,
  input  logic                left_place_i,
  input  teq_pkg::entry_t     right_i,
  output teq_pkg::entry_t     entry_o,
  output logic                place_o
);
  import teq_pkg::*;

  logic              valid_q, valid_d;
  logic [TIME_W-1:0] due_q, due_d;
  logic [TAG_W-1:0]  tag_q, tag_d;
  logic [SRC_W-1:0]  src_q, src_d;

  // new item goes at or before this slot when slot is empty or later
  assign place_o = !valid_q || (due_q > cmd_i.item.due);

  assign entry_o = '{valid: valid_q, due: due_q, tag: tag_q, src: src_q};

  // shift right on insert, shift left on pop
  always_comb begin
    valid_d = valid_q;
    due_d   = due_q;
    tag_d   = tag_q;
    src_d   = src_q;
    unique case (cmd_i.op)
      CH_INS: begin
        if (place_o) begin
          if (left_place_i) begin
            valid_d = left_i.valid;
            due_d   = left_i.due;
            tag_d   = left_i.tag;
            src_d   = left_i.src;
          end else begin
            valid_d = 1'b1;
            due_d   = cmd_i.item.due;
            tag_d   = cmd_i.item.tag;
            src_d   = cmd_i.item.src;
          end
        end
      end
      CH_POP: begin
        valid_d = right_i.valid;
        due_d   = right_i.due;
        tag_d   = right_i.tag;
        src_d   = right_i.src;
      end
      default: begin
      end
    endcase
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    due_q <= due_d;
    tag_q <= tag_d;
    src_q <= src_d;
  end

endmodule

[design/teq_chain.sv]
// teq_chain: row of teq_cell slots kept sorted by due time, head at slot 0
// depends on teq_pkg and teq_cell

module teq_chain (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  teq_pkg::chain_cmd_t cmd_i,
  output teq_pkg::entry_t     head_o
);
  import teq_pkg::*;

  entry_t cell_entry [QUEUE_DEPTH];
  logic   cell_place [QUEUE_DEPTH];

  // neighbor wiring
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_p;

    if (i == 0) begin : g_first
      assign left_e = '0;
      assign left_p = 1'b0;
    end else begin : g_mid_l
      assign left_e = cell_entry[i-1];
      assign left_p = cell_place[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_mid_r
      assign right_e = cell_entry[i+1];
    end

    teq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd_i),
      .left_i       (left_e),
      .left_place_i (left_p),
      .right_i      (right_e),
      .entry_o      (cell_entry[i]),
      .place_o      (cell_place[i])
    );
  end

  assign head_o = cell_entry[0];

endmodule
